@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define KFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kfr assertion failed");

// Check a property at every edge, reset included.
`define KFR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("kfr assertion failed");

`endif

@@ rtl/kfr_pkg.sv @@
package kfr_pkg;

    // KISS framing codes
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    localparam logic [3:0] CMD_DATA = 4'h0;

    // Record kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_BADCMD  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] port;
        logic [7:0] value;
        logic [9:0] length;
        logic       truncated;
    } t_rec;

    // Decoder result for one byte
    typedef struct packed {
        logic emit;
        t_rec rec;
    } t_res;

endpackage

@@ rtl/kfr_if.sv @@
// Received byte channel
interface kfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded record channel
interface kfr_rec_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] port;
    logic [7:0] value;
    logic [9:0] length;
    logic       truncated;

    modport source (output valid, output kind, output port, output value,
                    output length, output truncated, input ready);
    modport sink   (input valid, input kind, input port, input value,
                    input length, input truncated, output ready);
endinterface

@@ rtl/kfr_decoder.sv @@
module kfr_decoder #(
    parameter int MAX_FRAME = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_byte,
    output kfr_pkg::t_res o_res
);
    import kfr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME);
    localparam logic [CW-1:0] LAST = CW'(MAX_FRAME - 1);

    logic          r_await, n_await;
    logic          r_esc, n_esc;
    logic          r_frame, n_frame;
    logic [3:0]    r_port, n_port;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;

    logic [CW+9:0] w_cnt_ext;
    logic [9:0]    w_cnt10;

    // Low 10 bits of the count, zero-extended when the count is narrower
    assign w_cnt_ext = {10'b0, r_count};
    assign w_cnt10   = w_cnt_ext[9:0];

    // Next state and record for the byte in flight
    always_comb begin
        logic       pay;
        logic [7:0] pay_byte;
        pay      = 1'b0;
        pay_byte = i_byte;
        n_await  = r_await;
        n_esc    = r_esc;
        n_frame  = r_frame;
        n_port   = r_port;
        n_count  = r_count;
        n_ovf    = r_ovf;
        o_res    = '0;
        if (i_fire) begin
            if (r_await) begin
                if (i_byte != FEND) begin
                    n_await = 1'b0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    if (i_byte[3:0] == CMD_DATA) begin
                        n_port  = i_byte[7:4];
                        n_frame = 1'b1;
                    end else begin
                        o_res.emit       = 1'b1;
                        o_res.rec.kind   = KIND_BADCMD;
                        o_res.rec.port   = i_byte[7:4];
                        o_res.rec.value  = {4'b0, i_byte[3:0]};
                    end
                end
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_byte == TFEND) begin
                    pay      = 1'b1;
                    pay_byte = FEND;
                end else if (i_byte == TFESC) begin
                    pay      = 1'b1;
                    pay_byte = FESC;
                end
            end else if (i_byte == FEND) begin
                if (r_frame) begin
                    o_res.emit          = 1'b1;
                    o_res.rec.kind      = KIND_END;
                    o_res.rec.port      = r_port;
                    o_res.rec.length    = w_cnt10;
                    o_res.rec.truncated = r_ovf;
                end
                n_await = 1'b1;
                n_frame = 1'b0;
                n_esc   = 1'b0;
            end else if (i_byte == FESC) begin
                n_esc = 1'b1;
            end else begin
                pay = 1'b1;
            end

            // Payload byte: stream it out or drop it on overflow
            if (pay && r_frame) begin
                if (r_count < LAST) begin
                    o_res.emit       = 1'b1;
                    o_res.rec.kind   = KIND_PAYLOAD;
                    o_res.rec.port   = r_port;
                    o_res.rec.value  = pay_byte;
                    o_res.rec.length = w_cnt10;
                    n_count          = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    // Framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_esc   <= 1'b0;
            r_frame <= 1'b0;
            r_port  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_await <= n_await;
            r_esc   <= n_esc;
            r_frame <= n_frame;
            r_port  <= n_port;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ rtl/kfr_out_stage.sv @@
module kfr_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  kfr_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_free,
    output logic          o_valid,
    output kfr_pkg::t_rec o_rec
);
    import kfr_pkg::*;

    logic r_valid;
    t_rec r_rec;

    // Slot can take a new record when empty or being drained
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_fire && i_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_fire && i_res.emit) begin
            r_rec <= i_res.rec;
        end
    end

endmodule

@@ rtl/kiss_frame_receiver.sv @@
// KISS frame receiver: decodes one received byte per cycle, unless the record output
// stalls, into payload, end-of-frame and bad-command records.
// Path from byte request to record: input register, combinational decoder, result register.
// Throughput: 1 byte per cycle unless the output stalls; framing state updates per byte.
// Reset: synchronous active-low i_rst_n clears framing state and both stages.
module kiss_frame_receiver #(
    parameter int MAX_FRAME = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfr_byte_if.sink   i_rx,
    kfr_rec_if.source  o_rec
);
    import kfr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_free;
    logic       w_fire;
    t_res       w_res;
    t_rec       w_rec;

    assign w_fire     = r_in_valid && w_free;
    assign i_rx.ready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    kfr_decoder #(
        .MAX_FRAME (MAX_FRAME)
    ) u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    kfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_res   (w_res),
        .i_ready (o_rec.ready),
        .o_free  (w_free),
        .o_valid (o_rec.valid),
        .o_rec   (w_rec)
    );

    assign o_rec.kind      = w_rec.kind;
    assign o_rec.port      = w_rec.port;
    assign o_rec.value     = w_rec.value;
    assign o_rec.length    = w_rec.length;
    assign o_rec.truncated = w_rec.truncated;

endmodule

@@ rtl/kfr_chk.sv @@
`include "assert_macros.svh"

module kfr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_kind,
    input logic [7:0] i_value,
    input logic [9:0] i_length,
    input logic       i_truncated
);
    import kfr_pkg::*;

    // No record right after reset
    `KFR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

    // Only defined kinds leave the block
    `KFR_ASSERT(a_kind_known, i_clk, i_rst_n, i_out_valid |-> (i_kind == KIND_PAYLOAD || i_kind == KIND_END || i_kind == KIND_BADCMD))

    // Unused fields of each kind are zero
    `KFR_ASSERT(a_zero_fields, i_clk, i_rst_n, i_out_valid |-> ((i_kind == KIND_END && i_value == 8'd0) || (i_kind == KIND_PAYLOAD && !i_truncated) || (i_kind == KIND_BADCMD && i_length == 10'd0 && !i_truncated && i_value[7:4] == 4'd0)))

    // A stalled record holds its kind, value and length
    `KFR_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind) && $stable(i_value) && $stable(i_length)))

endmodule

bind kiss_frame_receiver kfr_chk u_kfr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rec.valid),
    .i_out_ready (o_rec.ready),
    .i_kind      (o_rec.kind),
    .i_value     (o_rec.value),
    .i_length    (o_rec.length),
    .i_truncated (o_rec.truncated)
);
